### rtl/csl_pkg.sv
// Package: token kinds, error codes, scan states and transfer types of the C source lexer.
package csl_pkg;

    localparam int KIND_W = 3;
    localparam int ERR_W  = 3;
    localparam int OUT_W  = 24;

    typedef enum logic [2:0] {
        KIND_NUM   = 3'd0,
        KIND_STR   = 3'd1,
        KIND_IDENT = 3'd2,
        KIND_KW    = 3'd3,
        KIND_PUNCT = 3'd4,
        KIND_END   = 3'd5,
        KIND_SBYTE = 3'd6,
        KIND_ERR   = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_UNCL_STR = 3'd1,
        ERR_UNCL_COM = 3'd2,
        ERR_BAD_HEX = 3'd3,
        ERR_INVALID = 3'd4
    } err_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_NUM   = 4'd1,
        ST_IDENT = 4'd2,
        ST_PUNCT = 4'd3,
        ST_STR   = 4'd4,
        ST_ESC   = 4'd5,
        ST_OCT   = 4'd6,
        ST_HEX0  = 4'd7,
        ST_HEX   = 4'd8,
        ST_LCOM  = 4'd9,
        ST_BCOM  = 4'd10,
        ST_BSTAR = 4'd11,
        ST_ERR   = 4'd12
    } scan_t;

    typedef enum logic [1:0] {
        CLS_SPACE = 2'd0,
        CLS_OTHER = 2'd1,
        CLS_BAD   = 2'd2
    } cls_t;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;

    // one classified byte handed from front to back
    typedef struct packed {
        logic       is_end;
        logic [7:0] ch;
        logic       is_digit;
        logic       is_alpha;
        logic       is_punct;
        logic       is_space;
        logic       is_hex;
        logic [3:0] hex_val;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] start;
        logic [23:0] len;
        logic [63:0] value;
        logic [23:0] line;
        logic [2:0]  err;
        logic        last;
    } tok_t;

    function automatic logic [7:0] letter_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h61:   r = 8'd7;
            8'h62:   r = 8'd8;
            8'h74:   r = 8'd9;
            8'h6e:   r = 8'd10;
            8'h76:   r = 8'd11;
            8'h66:   r = 8'd12;
            8'h72:   r = 8'd13;
            8'h65:   r = CH_ESC;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

### rtl/c_source_lexer.sv
// Top level of the C source lexer: front classifier, transfer queue and back scanner.
// Latency: an input transfer passes the front register and then the back output buffer before its first result.
// Throughput: one input byte per cycle while each byte gives at most one token and m_tready is high;
// a byte that gives two tokens holds the input until the second drains.
// Reset: aresetn synchronous, active low; offset 0, line 1, scanner idle, errors clear.
module c_source_lexer
    import csl_pkg::*;
#(
    parameter int MAX_KEYWORD_CHARS = 6,
    parameter int POSITION_BITS     = 24
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_byte
    input  logic         s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // start_offset, token_length, token_value,
                                    // line_number, error_code, zero fill
    output logic [2:0]   m_tuser,   // token_kind
    output logic         m_tlast
);

    logic  q_valid, q_ready;
    item_t q_item;
    tok_t  tok;

    csl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  ({s_tdata, s_tuser}),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    csl_back #(
        .MAX_KEYWORD_CHARS (MAX_KEYWORD_CHARS),
        .POSITION_BITS     (POSITION_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tok    (tok)
    );

    assign m_tdata = {5'd0, tok.err, tok.line, tok.value, tok.len, tok.start};
    assign m_tuser = tok.kind;
    assign m_tlast = tok.last;

endmodule

### rtl/csl_front.sv
// Front end: accepts input transfers and classifies each byte.
module csl_front
    import csl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [8:0] s_tdata,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic [7:0] c;

    assign c = s_tdata[8:1];

    always_comb begin
        item_next.is_end   = s_tdata[0] || (c == 8'd0);
        item_next.ch       = c;
        item_next.is_digit = (c >= 8'h30) && (c <= 8'h39);
        item_next.is_alpha = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
                             || (c == 8'h5f);
        item_next.is_punct = ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64))
                             || ((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));
        item_next.is_space = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
        item_next.is_hex   = 1'b1;
        item_next.hex_val  = 4'd0;
        if (item_next.is_digit) begin
            item_next.hex_val = c[3:0];
        end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
            item_next.hex_val = c[3:0] + 4'd9;
        end else begin
            item_next.is_hex = 1'b0;
        end
    end

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            item_reg <= item_next;
        end
    end

endmodule

### rtl/csl_back.sv
// Back end: scan state machine producing up to two tokens per byte.
module csl_back
    import csl_pkg::*;
#(
    parameter int MAX_KEYWORD_CHARS = 6,
    parameter int POSITION_BITS     = 24
)
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  q_valid,
    output logic  q_ready,
    input  item_t q_item,
    output logic  m_tvalid,
    input  logic  m_tready,
    output tok_t  m_tok
);

    localparam int IDX_W = $clog2(MAX_KEYWORD_CHARS);
    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

    scan_t scan_reg, scan_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, tstart_reg, tstart_next;
    logic [23:0] line_reg, line_next, tline_reg, tline_next;
    logic [63:0] acc_reg, acc_next;
    logic [7:0]  idc_reg [MAX_KEYWORD_CHARS];
    logic        idc_we;
    logic [IDX_W-1:0] idc_idx;
    logic [8:0]  esc_reg, esc_next;
    logic [1:0]  escd_reg, escd_next;
    logic [23:0] scnt_reg, scnt_next;
    logic [7:0]  pp_reg, pp_next;
    logic [2:0]  err_reg, err_next;
    logic        hb_reg, hb_next;
    logic [POSITION_BITS-1:0] hbpos_reg, hbpos_next;
    logic [23:0] hbline_reg, hbline_next;

    // two-entry output buffer
    tok_t o0_reg, o1_reg;
    logic [1:0] ocnt_reg;
    tok_t t0, t1;
    logic [1:0] n;

    logic [POSITION_BITS-1:0] cur_len;
    logic [7:0] c;
    logic take;
    logic is_kw;
    logic [63:0] acc_x10;
    logic acc_sat;

    assign c       = q_item.ch;
    assign cur_len = pos_reg - tstart_reg;
    assign q_ready = (ocnt_reg == 2'd0) || ((ocnt_reg == 2'd1) && m_tready);
    assign take    = q_valid && q_ready;
    assign m_tvalid = (ocnt_reg != 2'd0);
    assign m_tok    = o0_reg;

    // keyword match over stored characters
    function automatic logic kw_eq(input logic [7:0] a [MAX_KEYWORD_CHARS],
                                   input logic [47:0] s, input int k);
        logic r;
        r = 1'b1;
        for (int i = 0; i < 6; i++) begin
            if (i < k && i < MAX_KEYWORD_CHARS) begin
                if (a[i] != s[47-8*i -: 8]) r = 1'b0;
            end
        end
        return r;
    endfunction

    always_comb begin
        is_kw = 1'b0;
        case (cur_len)
            POSITION_BITS'(2): is_kw = kw_eq(idc_reg, {"if", 32'd0}, 2);
            POSITION_BITS'(3): is_kw = kw_eq(idc_reg, {"for", 24'd0}, 3)
                                    || kw_eq(idc_reg, {"int", 24'd0}, 3);
            POSITION_BITS'(4): is_kw = kw_eq(idc_reg, {"else", 16'd0}, 4)
                                    || kw_eq(idc_reg, {"char", 16'd0}, 4)
                                    || kw_eq(idc_reg, {"long", 16'd0}, 4);
            POSITION_BITS'(5): is_kw = kw_eq(idc_reg, {"while", 8'd0}, 5)
                                    || kw_eq(idc_reg, {"union", 8'd0}, 5)
                                    || kw_eq(idc_reg, {"short", 8'd0}, 5);
            POSITION_BITS'(6): is_kw = kw_eq(idc_reg, "return", 6)
                                    || kw_eq(idc_reg, "sizeof", 6)
                                    || kw_eq(idc_reg, "struct", 6);
            default: is_kw = 1'b0;
        endcase
    end

    assign acc_x10 = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0};
    // saturate when acc > (2^64-1-d)/10
    always_comb begin
        logic [67:0] wide;
        wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
               + {64'd0, q_item.ch[3:0]};
        acc_sat = |wide[67:64];
    end

    always_comb begin
        tok_t tk;
        logic done;
        logic [2:0] sv_err;
        logic [POSITION_BITS-1:0] sv_start;
        logic [23:0] sv_line;
        logic emit_err;
        logic [7:0] ebyte;
        logic do_ebyte, do_sbyte, do_start;

        scan_next   = scan_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        tstart_next = tstart_reg;
        tline_next  = tline_reg;
        acc_next    = acc_reg;
        esc_next    = esc_reg;
        escd_next   = escd_reg;
        scnt_next   = scnt_reg;
        pp_next     = pp_reg;
        err_next    = err_reg;
        hb_next     = hb_reg;
        hbpos_next  = hbpos_reg;
        hbline_next = hbline_reg;
        idc_we      = 1'b0;
        idc_idx     = '0;
        t0 = '0;
        t1 = '0;
        n  = 2'd0;
        emit_err = 1'b0;
        sv_err   = ERR_NONE;
        sv_start = '0;
        sv_line  = '0;
        ebyte    = '0;
        do_ebyte = 1'b0;
        do_sbyte = 1'b0;
        do_start = 1'b0;
        tk = '0;
        done = 1'b0;

        if (scan_reg == ST_ERR) begin
            t0.kind  = KIND_ERR;
            t0.start = 24'(tstart_reg);
            t0.line  = tline_reg;
            t0.err   = err_reg;
            n = 2'd1;
        end else if (q_item.is_end) begin
            case (scan_reg)
                ST_NUM: begin
                    tk.kind = KIND_NUM; tk.start = 24'(tstart_reg); tk.len = 24'(cur_len);
                    tk.value = acc_reg; tk.line = tline_reg; done = 1'b1;
                end
                ST_IDENT: begin
                    tk.kind = is_kw ? KIND_KW : KIND_IDENT; tk.start = 24'(tstart_reg);
                    tk.len = 24'(cur_len); tk.line = tline_reg; done = 1'b1;
                end
                ST_PUNCT: begin
                    tk.kind = KIND_PUNCT; tk.start = 24'(tstart_reg); tk.len = 24'd1;
                    tk.value = {56'd0, pp_reg}; tk.line = tline_reg; done = 1'b1;
                end
                ST_STR, ST_ESC, ST_OCT, ST_HEX0, ST_HEX: begin
                    emit_err = 1'b1; sv_err = ERR_UNCL_STR;
                    sv_start = tstart_reg + POS_ONE; sv_line = tline_reg;
                end
                ST_BCOM, ST_BSTAR: begin
                    emit_err = 1'b1; sv_err = ERR_UNCL_COM;
                    sv_start = tstart_reg; sv_line = tline_reg;
                end
                default: ;
            endcase
            if (!emit_err) begin
                if (done) begin
                    t0 = tk;
                    t1.kind = KIND_END; t1.start = 24'(pos_reg); t1.line = line_reg;
                    n = 2'd2;
                end else begin
                    t0.kind = KIND_END; t0.start = 24'(pos_reg); t0.line = line_reg;
                    n = 2'd1;
                end
                scan_next = ST_IDLE;
                pos_next  = '0;
                line_next = 24'd1;
            end
        end else begin
            case (scan_reg)
                ST_NUM: begin
                    if (q_item.is_digit) begin
                        acc_next = acc_sat ? '1 : acc_x10 + {60'd0, c[3:0]};
                    end else begin
                        tk.kind = KIND_NUM; tk.start = 24'(tstart_reg); tk.len = 24'(cur_len);
                        tk.value = acc_reg; tk.line = tline_reg; done = 1'b1;
                        do_start = 1'b1;
                    end
                end
                ST_IDENT: begin
                    if (q_item.is_alpha || q_item.is_digit) begin
                        if (cur_len < POSITION_BITS'(MAX_KEYWORD_CHARS)) begin
                            idc_we = 1'b1;
                            idc_idx = cur_len[IDX_W-1:0];
                        end
                    end else begin
                        tk.kind = is_kw ? KIND_KW : KIND_IDENT; tk.start = 24'(tstart_reg);
                        tk.len = 24'(cur_len); tk.line = tline_reg; done = 1'b1;
                        do_start = 1'b1;
                    end
                end
                ST_PUNCT: begin
                    if (pp_reg == "/" && c == "/") begin
                        scan_next = ST_LCOM;
                    end else if (pp_reg == "/" && c == "*") begin
                        scan_next = ST_BCOM;
                    end else if ((c == "=" && (pp_reg == "=" || pp_reg == "!" || pp_reg == "<"
                                  || pp_reg == ">")) || (pp_reg == "-" && c == ">")) begin
                        tk.kind = KIND_PUNCT; tk.start = 24'(tstart_reg); tk.len = 24'd2;
                        tk.value = {48'd0, c, pp_reg}; tk.line = tline_reg; done = 1'b1;
                        scan_next = ST_IDLE;
                    end else begin
                        tk.kind = KIND_PUNCT; tk.start = 24'(tstart_reg); tk.len = 24'd1;
                        tk.value = {56'd0, pp_reg}; tk.line = tline_reg; done = 1'b1;
                        do_start = 1'b1;
                    end
                end
                ST_STR: do_sbyte = 1'b1;
                ST_ESC: begin
                    if (c >= "0" && c <= "7") begin
                        esc_next = {6'd0, c[2:0]}; escd_next = 2'd1; scan_next = ST_OCT;
                    end else if (c == "x") begin
                        esc_next = '0; escd_next = 2'd0; scan_next = ST_HEX0;
                    end else begin
                        do_ebyte = 1'b1; ebyte = letter_escape(c);
                    end
                end
                ST_OCT: begin
                    if (c >= "0" && c <= "7" && escd_reg < 2'd3) begin
                        esc_next = {esc_reg[5:0], c[2:0]};
                        escd_next = escd_reg + 2'd1;
                        if (escd_reg == 2'd2) begin
                            do_ebyte = 1'b1; ebyte = esc_next[7:0];
                        end
                    end else begin
                        do_ebyte = 1'b1; ebyte = esc_reg[7:0]; do_sbyte = 1'b1;
                    end
                end
                ST_HEX0: begin
                    if (q_item.is_hex) begin
                        esc_next = {5'd0, q_item.hex_val}; scan_next = ST_HEX;
                    end else begin
                        if (!hb_reg) begin
                            hb_next = 1'b1; hbpos_next = pos_reg; hbline_next = line_reg;
                        end
                        scan_next = ST_STR;
                        do_sbyte = 1'b1;
                    end
                end
                ST_HEX: begin
                    if (q_item.is_hex) begin
                        esc_next = {1'b0, esc_reg[3:0], q_item.hex_val};
                    end else begin
                        do_ebyte = 1'b1; ebyte = esc_reg[7:0]; do_sbyte = 1'b1;
                    end
                end
                ST_LCOM: if (c == CH_NL) scan_next = ST_IDLE;
                ST_BCOM: if (c == "*") scan_next = ST_BSTAR;
                ST_BSTAR: begin
                    if (c == "/") scan_next = ST_IDLE;
                    else if (c != "*") scan_next = ST_BCOM;
                end
                default: do_start = 1'b1;
            endcase

            if (done) begin
                t0 = tk; n = 2'd1;
                if (scan_reg != ST_PUNCT || do_start) scan_next = ST_IDLE;
            end

            if (do_ebyte) begin
                t0.kind = KIND_SBYTE; t0.start = 24'(tstart_reg); t0.len = '0;
                t0.value = {56'd0, ebyte}; t0.line = tline_reg; t0.err = ERR_NONE;
                n = 2'd1;
                scnt_next = scnt_reg + 24'd1;
                scan_next = ST_STR;
            end

            if (do_sbyte) begin
                if (c == CH_QUOTE) begin
                    if (hb_next) begin
                        emit_err = 1'b1; sv_err = ERR_BAD_HEX;
                        sv_start = hbpos_next; sv_line = hbline_next;
                    end else begin
                        tk = '0;
                        tk.kind = KIND_STR; tk.start = 24'(tstart_reg);
                        tk.len = 24'(cur_len) + 24'd1;
                        tk.value = {40'd0, scnt_next + 24'd1}; tk.line = tline_reg;
                        if (n == 2'd0) t0 = tk; else t1 = tk;
                        n = n + 2'd1;
                        scan_next = ST_IDLE;
                    end
                end else if (c == CH_NL) begin
                    emit_err = 1'b1; sv_err = ERR_UNCL_STR;
                    sv_start = tstart_reg + POS_ONE; sv_line = tline_reg;
                end else if (c == CH_BSL) begin
                    scan_next = ST_ESC;
                end else begin
                    scnt_next = scnt_next + 24'd1;
                    scan_next = ST_STR;
                end
            end

            if (do_start) begin
                scan_next = ST_IDLE;
                if (q_item.is_space) begin
                    scan_next = ST_IDLE;
                end else if (q_item.is_digit) begin
                    scan_next = ST_NUM; tstart_next = pos_reg; tline_next = line_reg;
                    acc_next = {60'd0, c[3:0]};
                end else if (c == CH_QUOTE) begin
                    scan_next = ST_STR; tstart_next = pos_reg; tline_next = line_reg;
                    scnt_next = '0; hb_next = 1'b0;
                end else if (q_item.is_alpha) begin
                    scan_next = ST_IDENT; tstart_next = pos_reg; tline_next = line_reg;
                    idc_we = 1'b1; idc_idx = '0;
                end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "-"
                             || c == "/") begin
                    scan_next = ST_PUNCT; tstart_next = pos_reg; tline_next = line_reg;
                    pp_next = c;
                end else if (q_item.is_punct) begin
                    tk = '0;
                    tk.kind = KIND_PUNCT; tk.start = 24'(pos_reg); tk.len = 24'd1;
                    tk.value = {56'd0, c}; tk.line = line_reg;
                    if (n == 2'd0) t0 = tk; else t1 = tk;
                    n = n + 2'd1;
                end else begin
                    emit_err = 1'b1; sv_err = ERR_INVALID;
                    sv_start = pos_reg; sv_line = line_reg;
                end
            end

            pos_next = pos_reg + POS_ONE;
            if (c == CH_NL && line_reg != 24'hFFFFFF) line_next = line_reg + 24'd1;
        end

        if (emit_err) begin
            err_next    = sv_err;
            tstart_next = sv_start;
            tline_next  = sv_line;
            scan_next   = ST_ERR;
            t0 = '0;
            t0.kind  = KIND_ERR;
            t0.start = 24'(sv_start);
            t0.line  = sv_line;
            t0.err   = sv_err;
            t1 = '0;
            n = 2'd1;
        end

        if (n == 2'd1) t0.last = 1'b1;
        if (n == 2'd2) t1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg   <= ST_IDLE;
            pos_reg    <= '0;
            line_reg   <= 24'd1;
            tstart_reg <= '0;
            tline_reg  <= 24'd1;
            acc_reg    <= '0;
            esc_reg    <= '0;
            escd_reg   <= '0;
            scnt_reg   <= '0;
            pp_reg     <= '0;
            err_reg    <= ERR_NONE;
            hb_reg     <= 1'b0;
            hbpos_reg  <= '0;
            hbline_reg <= 24'd1;
            ocnt_reg   <= 2'd0;
        end else begin
            if (take) begin
                scan_reg   <= scan_next;
                pos_reg    <= pos_next;
                line_reg   <= line_next;
                tstart_reg <= tstart_next;
                tline_reg  <= tline_next;
                acc_reg    <= acc_next;
                esc_reg    <= esc_next;
                escd_reg   <= escd_next;
                scnt_reg   <= scnt_next;
                pp_reg     <= pp_next;
                err_reg    <= err_next;
                hb_reg     <= hb_next;
                hbpos_reg  <= hbpos_next;
                hbline_reg <= hbline_next;
                ocnt_reg   <= n;
            end else if (m_tvalid && m_tready) begin
                ocnt_reg <= ocnt_reg - 2'd1;
            end
        end
        if (take) begin
            if (ocnt_reg == 2'd0 || n != 2'd0) begin
                o0_reg <= t0;
            end
            o1_reg <= t1;
        end else if (m_tvalid && m_tready) begin
            o0_reg <= o1_reg;
        end
        if (take && idc_we) begin
            idc_reg[idc_idx] <= c;
        end
    end

endmodule
